[hw/rtl/stlx_pkg.sv]
// ----------------------------------------------------------------------------
// stlx_pkg
// shared types, codes, keyword table and helper functions of the schema lexer
// ----------------------------------------------------------------------------
`default_nettype none

package stlx_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int KW_COUNT  = 10;
    localparam int KW_MAXLEN = 8;

    // token queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR
    } mode_t;

    localparam logic [4:0] KIND_NUMBER   = 5'd0;
    localparam logic [4:0] KIND_IDENT    = 5'd1;
    localparam logic [4:0] KIND_LBRACE   = 5'd2;
    localparam logic [4:0] KIND_RBRACE   = 5'd3;
    localparam logic [4:0] KIND_EQUALS   = 5'd4;
    localparam logic [4:0] KIND_SEMI     = 5'd5;
    localparam logic [4:0] KIND_SLASH    = 5'd6;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd7;
    localparam logic [4:0] KIND_LAST     = 5'd16;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef logic [KW_COUNT-1:0] kw_mask_t;

    // keywords in kind order, zero filled
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"m", "e", "s", "s", "a", "g", "e", 8'h00},
        '{"r", "e", "q", "u", "i", "r", "e", "d"},
        '{"o", "p", "t", "i", "o", "n", "a", "l"},
        '{"r", "e", "p", "e", "a", "t", "e", "d"},
        '{"i", "n", "t", "3", "2", 8'h00, 8'h00, 8'h00},
        '{"u", "i", "n", "t", "3", "2", 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"f", "i", "x", "e", "d", "3", "2", 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd8, 4'd8, 4'd8, 4'd5, 4'd6, 4'd4, 4'd6, 4'd7, 4'd5
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
    } token_t;

    // up to two tokens caused by one byte, first always present
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } bundle_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // drop keywords that cannot hold byte c at position idx
    function automatic kw_mask_t kw_narrow(kw_mask_t mask, logic [15:0] idx, logic [7:0] c);
        kw_mask_t res;
        for (int k = 0; k < KW_COUNT; k++) begin
            res[k] = mask[k] && (idx < 16'(KW_LEN[k])) && (KW_TEXT[k][idx[2:0]] == c);
        end
        return res;
    endfunction

    // identifiers that spell a keyword in full get the keyword kind
    function automatic logic [4:0] kw_resolve(logic [4:0] kind, logic ident,
                                              kw_mask_t mask, logic [15:0] count);
        logic [4:0] res;
        res = kind;
        if (ident)
        begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (mask[k] && (count == 16'(KW_LEN[k])))
                begin
                    res = KIND_KEYWORD0 + 5'(k);
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stlx_front.sv]
// ----------------------------------------------------------------------------
// stlx_front
// per-byte lexer state machine, forms token bundles and pushes them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module stlx_front #(
    parameter int POSITION_BITS = stlx_pkg::POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = stlx_pkg::OFFSET_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tlast,
    input  wire logic             q_ready,
    output logic                  push,
    output stlx_pkg::bundle_t     push_bundle
);

    stlx_pkg::mode_t             mode_reg, mode_next;
    logic [4:0]                  kind_reg, kind_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [POSITION_BITS-1:0]    line_reg, line_next;
    logic [POSITION_BITS-1:0]    col_reg, col_next;
    logic [OFFSET_BITS-1:0]      start_off_reg, start_off_next;
    logic [POSITION_BITS-1:0]    start_line_reg, start_line_next;
    logic [POSITION_BITS-1:0]    start_col_reg, start_col_next;
    logic [15:0]                 count_reg, count_next;
    stlx_pkg::kw_mask_t          cand_reg, cand_next;

    logic                        accept;
    logic                        dig, alp;
    logic                        emit_old, feed;
    logic                        single_v;
    logic [4:0]                  single_kind;
    logic                        flush_v;
    logic [15:0]                 count_inc;
    stlx_pkg::token_t            tok_old, tok_single, tok_flush, tok_late;
    logic                        late_v;

    assign s_tready = q_ready;
    assign accept   = s_tvalid & q_ready;
    assign dig      = stlx_pkg::is_digit(s_tdata);
    assign alp      = stlx_pkg::is_alpha(s_tdata);
    assign count_inc = (count_reg == stlx_pkg::LEN_MAX) ? count_reg : count_reg + 16'd1;

    always_comb
    begin
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        start_off_next  = start_off_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        count_next      = count_reg;
        cand_next       = cand_reg;
        emit_old        = 1'b0;
        feed            = 1'b0;
        single_v        = 1'b0;
        single_kind     = stlx_pkg::KIND_LBRACE;

        case (mode_reg)
            stlx_pkg::MODE_NUMBER:
            begin
                if (dig)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    emit_old = 1'b1;
                    feed     = 1'b1;
                end
            end
            stlx_pkg::MODE_IDENT:
            begin
                if (dig || alp)
                begin
                    cand_next  = stlx_pkg::kw_narrow(cand_reg, count_reg, s_tdata);
                    count_next = count_inc;
                end
                else
                begin
                    emit_old = 1'b1;
                    feed     = 1'b1;
                end
            end
            stlx_pkg::MODE_SLASH:
            begin
                if (s_tdata == stlx_pkg::CH_SLASH)
                begin
                    mode_next = stlx_pkg::MODE_LINE;
                end
                else if (s_tdata == stlx_pkg::CH_STAR)
                begin
                    mode_next = stlx_pkg::MODE_BLOCK;
                end
                else
                begin
                    emit_old = 1'b1;
                    feed     = 1'b1;
                end
            end
            stlx_pkg::MODE_LINE:
            begin
                if (s_tdata == stlx_pkg::CH_NEWLINE)
                begin
                    mode_next = stlx_pkg::MODE_IDLE;
                end
            end
            stlx_pkg::MODE_BLOCK:
            begin
                if (s_tdata == stlx_pkg::CH_STAR)
                begin
                    mode_next = stlx_pkg::MODE_STAR;
                end
            end
            stlx_pkg::MODE_STAR:
            begin
                if (s_tdata == stlx_pkg::CH_SLASH)
                begin
                    mode_next = stlx_pkg::MODE_IDLE;
                end
                else if (s_tdata != stlx_pkg::CH_STAR)
                begin
                    mode_next = stlx_pkg::MODE_BLOCK;
                end
            end
            default:
            begin
                feed = 1'b1;
            end
        endcase

        // byte taken as in idle: start a token, form a one-byte token or skip it
        if (feed)
        begin
            mode_next = stlx_pkg::MODE_IDLE;
            if (dig || alp || (s_tdata == stlx_pkg::CH_SLASH))
            begin
                start_off_next  = pos_reg;
                start_line_next = line_reg;
                start_col_next  = col_reg;
                count_next      = 16'd1;
                if (dig)
                begin
                    mode_next = stlx_pkg::MODE_NUMBER;
                    kind_next = stlx_pkg::KIND_NUMBER;
                end
                else if (alp)
                begin
                    mode_next = stlx_pkg::MODE_IDENT;
                    kind_next = stlx_pkg::KIND_IDENT;
                    cand_next = stlx_pkg::kw_narrow('1, 16'd0, s_tdata);
                end
                else
                begin
                    mode_next = stlx_pkg::MODE_SLASH;
                    kind_next = stlx_pkg::KIND_SLASH;
                end
            end
            else if (s_tdata == stlx_pkg::CH_LBRACE)
            begin
                single_v    = 1'b1;
                single_kind = stlx_pkg::KIND_LBRACE;
            end
            else if (s_tdata == stlx_pkg::CH_RBRACE)
            begin
                single_v    = 1'b1;
                single_kind = stlx_pkg::KIND_RBRACE;
            end
            else if (s_tdata == stlx_pkg::CH_EQUALS)
            begin
                single_v    = 1'b1;
                single_kind = stlx_pkg::KIND_EQUALS;
            end
            else if (s_tdata == stlx_pkg::CH_SEMI)
            begin
                single_v    = 1'b1;
                single_kind = stlx_pkg::KIND_SEMI;
            end
        end
    end

    assign flush_v = s_tlast && ((mode_next == stlx_pkg::MODE_NUMBER) ||
                                 (mode_next == stlx_pkg::MODE_IDENT) ||
                                 (mode_next == stlx_pkg::MODE_SLASH));

    always_comb
    begin
        tok_old.kind   = stlx_pkg::kw_resolve(kind_reg, mode_reg == stlx_pkg::MODE_IDENT,
                                              cand_reg, count_reg);
        tok_old.offset = 32'(start_off_reg);
        tok_old.length = count_reg;
        tok_old.line   = 16'(start_line_reg);
        tok_old.column = 16'(start_col_reg);

        tok_single.kind   = single_kind;
        tok_single.offset = 32'(pos_reg);
        tok_single.length = 16'd1;
        tok_single.line   = 16'(line_reg);
        tok_single.column = 16'(col_reg);

        tok_flush.kind   = stlx_pkg::kw_resolve(kind_next, mode_next == stlx_pkg::MODE_IDENT,
                                                cand_next, count_next);
        tok_flush.offset = 32'(start_off_next);
        tok_flush.length = count_next;
        tok_flush.line   = 16'(start_line_next);
        tok_flush.column = 16'(start_col_next);

        // a one-byte token and an end flush never come from the same byte
        late_v   = single_v | flush_v;
        tok_late = single_v ? tok_single : tok_flush;

        push_bundle.two    = emit_old & late_v;
        push_bundle.first  = emit_old ? tok_old : tok_late;
        push_bundle.second = tok_late;
        push               = accept & (emit_old | late_v);
    end

    always_comb
    begin
        pos_next = pos_reg + OFFSET_BITS'(1);
        line_next = line_reg;
        col_next  = col_reg;
        if (s_tdata == stlx_pkg::CH_NEWLINE)
        begin
            if (!(&line_reg))
            begin
                line_next = line_reg + POSITION_BITS'(1);
            end
            col_next = POSITION_BITS'(1);
        end
        else if (!(&col_reg))
        begin
            col_next = col_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stlx_pkg::MODE_IDLE;
            kind_reg       <= stlx_pkg::KIND_NUMBER;
            pos_reg        <= '0;
            line_reg       <= POSITION_BITS'(1);
            col_reg        <= POSITION_BITS'(1);
            start_off_reg  <= '0;
            start_line_reg <= POSITION_BITS'(1);
            start_col_reg  <= POSITION_BITS'(1);
            count_reg      <= '0;
            cand_reg       <= '1;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // end of text: back to the start state
                mode_reg       <= stlx_pkg::MODE_IDLE;
                kind_reg       <= stlx_pkg::KIND_NUMBER;
                pos_reg        <= '0;
                line_reg       <= POSITION_BITS'(1);
                col_reg        <= POSITION_BITS'(1);
                start_off_reg  <= '0;
                start_line_reg <= POSITION_BITS'(1);
                start_col_reg  <= POSITION_BITS'(1);
                count_reg      <= '0;
                cand_reg       <= '1;
            end
            else
            begin
                mode_reg       <= mode_next;
                kind_reg       <= kind_next;
                pos_reg        <= pos_next;
                line_reg       <= line_next;
                col_reg        <= col_next;
                start_off_reg  <= start_off_next;
                start_line_reg <= start_line_next;
                start_col_reg  <= start_col_next;
                count_reg      <= count_next;
                cand_reg       <= cand_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stlx_queue.sv]
// ----------------------------------------------------------------------------
// stlx_queue
// short first-in first-out queue of token bundles between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module stlx_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire stlx_pkg::bundle_t push_bundle,
    output logic                   ready,
    input  wire logic              pop,
    output logic                   pop_valid,
    output stlx_pkg::bundle_t      pop_bundle
);

    localparam logic [stlx_pkg::QPTR_BITS:0] FULL_COUNT =
        (stlx_pkg::QPTR_BITS+1)'(stlx_pkg::QUEUE_DEPTH);

    stlx_pkg::bundle_t                slot_reg [stlx_pkg::QUEUE_DEPTH];
    logic [stlx_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stlx_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stlx_pkg::QPTR_BITS:0]     count_reg, count_next;
    logic                             do_push, do_pop;

    assign ready      = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_bundle = slot_reg[rd_ptr_reg];
    assign do_push    = push & ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + stlx_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + stlx_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (stlx_pkg::QPTR_BITS+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (stlx_pkg::QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stlx_emit.sv]
// ----------------------------------------------------------------------------
// stlx_emit
// back end: splits bundles into single results and drives the output register
// ----------------------------------------------------------------------------
`default_nettype none

module stlx_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire stlx_pkg::bundle_t q_bundle,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [79:0]            m_tdata,
    output logic [4:0]             m_tuser,
    output logic                   m_tlast
);

    logic               out_valid_reg, out_valid_next;
    stlx_pkg::token_t   out_tok_reg, out_tok_next;
    logic               out_last_reg, out_last_next;
    logic               hold_valid_reg, hold_valid_next;
    stlx_pkg::token_t   hold_tok_reg, hold_tok_next;
    logic               load;

    assign load  = !out_valid_reg || m_tready;
    assign q_pop = load && !hold_valid_reg && q_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_tok_next    = out_tok_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_tok_next   = hold_tok_reg;
        if (load)
        begin
            if (hold_valid_reg)
            begin
                // second token of the bundle closes the run
                out_valid_next  = 1'b1;
                out_tok_next    = hold_tok_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (q_valid)
            begin
                out_valid_next  = 1'b1;
                out_tok_next    = q_bundle.first;
                out_last_next   = !q_bundle.two;
                hold_valid_next = q_bundle.two;
                hold_tok_next   = q_bundle.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
        hold_tok_reg <= hold_tok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_tok_reg.kind;
    assign m_tdata  = {out_tok_reg.column, out_tok_reg.line, out_tok_reg.length,
                       out_tok_reg.offset};

endmodule

`default_nettype wire

[hw/rtl/schema_text_lexer_core.sv]
// ----------------------------------------------------------------------------
// schema_text_lexer_core
// schema text lexer: bytes in, tokens with kind, offset, length, line, column out
// ----------------------------------------------------------------------------
// usage:
//   input stream: one text byte per transfer on s_tdata, s_tlast marks the last
//   byte of a text; after it any open token is flushed and the lexer restarts
//   at offset 0, line 1, column 1
//   output stream: one token per transfer, kind on m_tuser, position fields on
//   m_tdata; a byte causes zero, one or two tokens, and m_tlast is set on the
//   last token caused by one byte
//   throughput: one byte per cycle while the queue has room; the per-byte state
//   update and keyword narrowing are combinational in the front end
//   results leave at one per cycle while m_tready is high; a byte that gives
//   two tokens takes two output transfers; a four-entry bundle queue absorbs
//   such bursts; tokens go through the queue and then the output register
//   reset: lexer back to idle, positions at their start values, queue and
//   output register empty
//   receiver stall: the output register holds its token, the queue fills, and
//   s_tready drops only once the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module schema_text_lexer_core #(
    parameter int POSITION_BITS = stlx_pkg::POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = stlx_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // text bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // end_of_text
    // tokens
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // start_offset, token_length,
                                        // start_line, start_column
    output logic [4:0]       m_tuser,   // token_kind
    output logic             m_tlast    // last_of_run
);

    logic               push;
    stlx_pkg::bundle_t  push_bundle;
    logic               q_ready;
    logic               q_valid;
    logic               q_pop;
    stlx_pkg::bundle_t  q_bundle;

    // front end: mode machine, positions and keyword candidates
    stlx_front #(
        .POSITION_BITS (POSITION_BITS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_ready     (q_ready),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // bundles of one or two tokens wait here
    stlx_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .ready       (q_ready),
        .pop         (q_pop),
        .pop_valid   (q_valid),
        .pop_bundle  (q_bundle)
    );

    // back end: one token per output transfer
    stlx_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_bundle (q_bundle),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/stlx_checker.sv]
// ----------------------------------------------------------------------------
// stlx_checker
// port-level checks of the schema lexer token stream
// ----------------------------------------------------------------------------
`default_nettype none

module stlx_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic [4:0]  m_tuser,
    input  wire logic        m_tlast
);

    logic [4:0]  kind;
    logic [15:0] length;

    assign kind   = m_tuser;
    assign length = m_tdata[47:32];

    // stalled token stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("token dropped while stalled");

    // stalled token does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("token changed while stalled");

    // kind code within the defined range
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> kind <= stlx_pkg::KIND_LAST)
        else $error("token kind out of range");

    // braces, equals, semicolon and stray slash are one byte long
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind >= stlx_pkg::KIND_LBRACE && kind <= stlx_pkg::KIND_SLASH
        |-> length == 16'd1)
        else $error("single-byte token with wrong length");

    // keywords are four to eight bytes long
    a_keyword_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind >= stlx_pkg::KIND_KEYWORD0
        |-> length >= 16'd4 && length <= 16'd8)
        else $error("keyword token with wrong length");

endmodule

bind schema_text_lexer_core stlx_checker u_stlx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
